>>> design/e2r_pkg.sv
// Package for the Euler angle to rotation matrix block.
// Holds the payload structs and fixed-point constants; no dependencies.
package e2r_pkg;

  localparam int unsigned InBits  = 16;
  localparam int unsigned OutBits = 16;
  localparam int unsigned QBits   = 30;
  localparam logic [32:0] HalfPiQ32 = 33'd6746518852;
  localparam logic signed [31:0] OneQ = 32'sd1073741824;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } e2r_in_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } e2r_out_t;

  // Q30 product rounded half away from zero.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    logic [63:0] m;
    begin
      p = 64'(a) * 64'(b);
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + 64'(1 << (QBits - 1))) >> QBits;
      mulq = p[63] ? -32'(m) : 32'(m);
    end
  endfunction

endpackage

>>> design/e2r_cell.sv
// One pipeline cell: a series step of cosine, and of sine if K <= 6, for a lane.
// Depends on e2r_pkg. Passes its terms and partial sums to the next cell.
module e2r_cell #(
  parameter int unsigned K = 1
) (
  input  logic               clk_i,
  input  logic        [31:0] x2_i,
  input  logic        [31:0] ts_i,
  input  logic        [31:0] tc_i,
  input  logic signed [33:0] s_i,
  input  logic signed [33:0] c_i,
  output logic        [31:0] ts_o,
  output logic        [31:0] tc_o,
  output logic signed [33:0] s_o,
  output logic signed [33:0] c_o
);
  import e2r_pkg::*;

  localparam int unsigned DivS = (2 * K) * (2 * K + 1);
  localparam int unsigned DivC = (2 * K - 1) * (2 * K);
  localparam int unsigned LogS = $clog2(DivS);
  localparam int unsigned LogC = $clog2(DivC);
  // Rounded-up reciprocals give an exact floor quotient for any 32-bit dividend.
  localparam logic [63:0] RecS =
    ((64'd1 << (32 + LogS)) + 64'(DivS) - 64'd1) / 64'(DivS);
  localparam logic [63:0] RecC =
    ((64'd1 << (32 + LogC)) + 64'(DivC) - 64'd1) / 64'(DivC);

  logic [63:0] ps, pc;
  logic [31:0] ps_q, pc_q, ts_q;
  logic signed [33:0] s_q, c_q;
  logic [71:0] qs, qc;
  logic [31:0] ts_d, tc_d;

  always_comb begin
    ps = 64'(ts_i) * 64'(x2_i);
    pc = 64'(tc_i) * 64'(x2_i);
    qs = 72'(ps_q) * 72'(RecS);
    qc = 72'(pc_q) * 72'(RecC);
    ts_d = 32'(qs >> (32 + LogS));
    tc_d = 32'(qc >> (32 + LogC));
  end

  // The product with x squared is registered first, then the division.
  always_ff @(posedge clk_i) begin
    ps_q <= 32'(ps >> QBits);
    pc_q <= 32'(pc >> QBits);
    ts_q <= ts_i;
    s_q  <= s_i;
    c_q  <= c_i;
  end

  always_ff @(posedge clk_i) begin
    ts_o <= (K <= 6) ? ts_d : ts_q;
    tc_o <= tc_d;
    if (K <= 6) begin
      s_o <= (K % 2 == 1) ? s_q - 34'(ts_d) : s_q + 34'(ts_d);
    end else begin
      s_o <= s_q;
    end
    c_o <= (K % 2 == 1) ? c_q - 34'(tc_d) : c_q + 34'(tc_d);
  end
endmodule

>>> design/e2r_sincos.sv
// Sine and cosine of one negated binary angle, as a chain of series cells.
// Depends on e2r_pkg and e2r_cell.
module e2r_sincos #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic        [15:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import e2r_pkg::*;

  localparam int unsigned Qs = ANGLE_BITS - 2;
  localparam int unsigned Steps = 7;

  logic [ANGLE_BITS-1:0] a;
  logic [1:0]  quad_q [Steps+2];
  logic [1:0]  quad_m [Steps];
  logic [31:0] x_q, x2_q;
  logic [31:0] x2_p [Steps+1];
  logic [31:0] x2_m [Steps];
  logic [31:0] ts [Steps+1];
  logic [31:0] tc [Steps+1];
  logic signed [33:0] s [Steps+1];
  logic signed [33:0] c [Steps+1];
  logic signed [31:0] sc, cc;

  always_comb begin
    if (ANGLE_BITS >= InBits) begin
      a = ANGLE_BITS'(angle_i) << (ANGLE_BITS - InBits);
    end else begin
      a = ANGLE_BITS'(angle_i >> (InBits - ANGLE_BITS));
    end
    a = -a;
  end

  // Stage 0: radian argument. Stage 1: its square.
  always_ff @(posedge clk_i) begin
    quad_q[0] <= a[ANGLE_BITS-1 -: 2];
    x_q <= 32'(((64'(a[Qs-1:0]) * 64'(HalfPiQ32)) +
                (64'(1) << (ANGLE_BITS - 1))) >> ANGLE_BITS);
    quad_q[1] <= quad_q[0];
    x2_q <= 32'((64'(x_q) * 64'(x_q)) >> QBits);
    ts[0] <= x_q;
    s[0]  <= 34'(x_q);
  end

  assign x2_p[0] = x2_q;
  assign tc[0] = 32'(OneQ);
  assign c[0]  = 34'(OneQ);

  // The square and quadrant are registered alongside each cell's product and division.
  for (genvar k = 0; k < Steps; k++) begin : g_cell
    e2r_cell #(.K(k + 1)) u_cell (
      .clk_i, .x2_i(x2_p[k]), .ts_i(ts[k]), .tc_i(tc[k]),
      .s_i(s[k]), .c_i(c[k]),
      .ts_o(ts[k+1]), .tc_o(tc[k+1]), .s_o(s[k+1]), .c_o(c[k+1])
    );
    always_ff @(posedge clk_i) begin
      x2_m[k] <= x2_p[k];
      x2_p[k+1] <= x2_m[k];
      quad_m[k] <= quad_q[k+1];
      quad_q[k+2] <= quad_m[k];
    end
  end

  always_comb begin
    sc = s[Steps] < 0 ? 32'sd0 : (s[Steps] > 34'(OneQ) ? OneQ : 32'(s[Steps]));
    cc = c[Steps] < 0 ? 32'sd0 : (c[Steps] > 34'(OneQ) ? OneQ : 32'(c[Steps]));
  end

  always_ff @(posedge clk_i) begin
    unique case (quad_q[Steps+1])
      2'd0: begin sin_o <= sc;  cos_o <= cc;  end
      2'd1: begin sin_o <= cc;  cos_o <= -sc; end
      2'd2: begin sin_o <= -sc; cos_o <= -cc; end
      default: begin sin_o <= -cc; cos_o <= sc; end
    endcase
  end
endmodule

>>> design/euler_to_rotation_matrix.sv
// Top level of the Euler angle to rotation matrix block.
// Depends on e2r_pkg and e2r_sincos.
//
// Usage: drive in_i with three binary angles and raise start; busy is
// always low, so a beat is taken in every cycle with start high. The nine
// Q2.14 entries of Rz*Ry*Rx (negated angles) later appear on out_o with
// valid_o high for one cycle. Throughput is one triple per clock. The
// argument and its square are registered first, then come seven series
// cells (product, then division by a reciprocal multiply), the quadrant
// map, the first products and the second products with output rounding.
// The receiver cannot stall; each result stands for one cycle. Reset
// clears the valid pipeline only.
module euler_to_rotation_matrix #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  e2r_pkg::e2r_in_t  in_i,
  output logic              valid_o,
  output e2r_pkg::e2r_out_t out_o
);
  import e2r_pkg::*;

  localparam int unsigned Lat = 19;
  localparam int unsigned Sh = QBits - FRAC_BITS;

  logic [Lat-1:0] vld_q;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  logic signed [31:0] sxsy_q, cxsy_q, sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;

  function automatic logic [15:0] out_entry(input logic signed [33:0] v);
    logic [33:0] m;
    logic signed [33:0] r;
    logic signed [33:0] lim;
    begin
      lim = 34'sd1 <<< FRAC_BITS;
      m = v[33] ? 34'(-v) : 34'(v);
      m = (m + (34'd1 << (Sh - 1))) >> Sh;
      r = v[33] ? -34'(m) : 34'(m);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      out_entry = r[15:0];
    end
  endfunction

  assign busy = 1'b0;

  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_x (.clk_i, .angle_i(in_i.angle_x),
    .sin_o(sx), .cos_o(cx));
  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_y (.clk_i, .angle_i(in_i.angle_y),
    .sin_o(sy), .cos_o(cy));
  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_z (.clk_i, .angle_i(in_i.angle_z),
    .sin_o(sz), .cos_o(cz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    sxsy_q <= mulq(sx, sy);
    cxsy_q <= mulq(cx, sy);
    sx_q <= sx; cx_q <= cx; sy_q <= sy; cy_q <= cy; sz_q <= sz; cz_q <= cz;
    out_o.r00 <= out_entry(34'(mulq(cy_q, cz_q)));
    out_o.r01 <= out_entry(34'(mulq(sxsy_q, cz_q)) - 34'(mulq(cx_q, sz_q)));
    out_o.r02 <= out_entry(34'(mulq(cxsy_q, cz_q)) + 34'(mulq(sx_q, sz_q)));
    out_o.r10 <= out_entry(34'(mulq(cy_q, sz_q)));
    out_o.r11 <= out_entry(34'(mulq(sxsy_q, sz_q)) + 34'(mulq(cx_q, cz_q)));
    out_o.r12 <= out_entry(34'(mulq(cxsy_q, sz_q)) - 34'(mulq(sx_q, cz_q)));
    out_o.r20 <= out_entry(-34'(sy_q));
    out_o.r21 <= out_entry(34'(mulq(sx_q, cy_q)));
    out_o.r22 <= out_entry(34'(mulq(cx_q, cy_q)));
  end

  assign valid_o = vld_q[Lat-1];
endmodule

>>> design/e2r_checker.sv
// Port checker for the Euler angle to rotation matrix block.
// Depends on e2r_pkg; bound to the top level below.
module e2r_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              valid_o,
  input e2r_pkg::e2r_out_t out_o
);
  import e2r_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##19 valid_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 19)) else $error("result invented");
  a_r20_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(out_o.r20) <= 16'sd16384 && $signed(out_o.r20) >= -16'sd16384))
    else $error("entry out of range");
endmodule

bind euler_to_rotation_matrix e2r_checker u_e2r_checker (.*);

>>> tb/sv/euler_to_rotation_matrix_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for euler_to_rotation_matrix.
// Depends on e2r_pkg and the block; predicts each matrix from the angles.
module euler_to_rotation_matrix_test;
  import e2r_pkg::*;

  localparam int unsigned AngleBits = 16;
  localparam int unsigned FracBits  = 14;
  localparam int unsigned Latency   = 19;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [63:0] HalfPi = 64'd6746518852;
  localparam longint QOne = 64'sd1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  e2r_in_t in_i = '0;
  logic valid_o;
  e2r_out_t out_o;

  e2r_in_t angle_q[$];
  e2r_out_t matrix_q[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  int unsigned wait_cnt = 0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;

  euler_to_rotation_matrix uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .valid_o(valid_o), .out_o(out_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint rnd_shift(longint v, int unsigned sh);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, 30);
  endfunction

  // Series sine and cosine of a negated binary angle, Q30.
  function automatic void sin_cos(logic [15:0] raw, output longint sn,
                                  output longint cs);
    logic [AngleBits-1:0] a;
    logic [1:0] quad;
    logic [63:0] r, x, x2, t;
    longint s, c;
    a = -raw;
    quad = a[AngleBits-1 -: 2];
    r = 64'(a[AngleBits-3:0]);
    x = (r * HalfPi + (64'd1 << (AngleBits - 1))) >> AngleBits;
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      s += (k % 2) ? -longint'(t) : longint'(t);
    end
    t = 64'(QOne);
    c = QOne;
    for (int k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      c += (k % 2) ? -longint'(t) : longint'(t);
    end
    if (s < 0) s = 0;
    if (s > QOne) s = QOne;
    if (c < 0) c = 0;
    if (c > QOne) c = QOne;
    case (quad)
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic signed [15:0] to_entry(longint v);
    longint r;
    r = rnd_shift(v, 30 - FracBits);
    if (r > (64'sd1 <<< FracBits)) r = 64'sd1 <<< FracBits;
    if (r < -(64'sd1 <<< FracBits)) r = -(64'sd1 <<< FracBits);
    return r[15:0];
  endfunction

  function automatic e2r_out_t rotation_of(e2r_in_t ang);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    e2r_out_t m;
    sin_cos(ang.angle_x, sx, cx);
    sin_cos(ang.angle_y, sy, cy);
    sin_cos(ang.angle_z, sz, cz);
    sxsy = qmul(sx, sy);
    cxsy = qmul(cx, sy);
    m.r00 = to_entry(qmul(cy, cz));
    m.r01 = to_entry(qmul(sxsy, cz) - qmul(cx, sz));
    m.r02 = to_entry(qmul(cxsy, cz) + qmul(sx, sz));
    m.r10 = to_entry(qmul(cy, sz));
    m.r11 = to_entry(qmul(sxsy, sz) + qmul(cx, cz));
    m.r12 = to_entry(qmul(cxsy, sz) - qmul(sx, cz));
    m.r20 = to_entry(-sy);
    m.r21 = to_entry(qmul(sx, cy));
    m.r22 = to_entry(qmul(cx, cy));
    return m;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch on beat %0d field %s: got %0d expected %0d", received,
             field, $signed(got), $signed(want));
  endtask

  task automatic add_triple(int ax, int ay, int az);
    e2r_in_t t;
    t.angle_x = ax[15:0];
    t.angle_y = ay[15:0];
    t.angle_z = az[15:0];
    angle_q.push_back(t);
  endtask

  // Draws the idle gap before the next beat, with about two fifths of the beats back to back.
  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  initial begin
    int vals[8];
    vals = '{0, 16384, -16384, -32768, 32767, 1, -1, 8192};
    for (int i = 0; i < 8; i++) add_triple(vals[i], 0, 0);
    for (int i = 0; i < 8; i++) add_triple(0, vals[i], 0);
    for (int i = 0; i < 8; i++) add_triple(0, 0, vals[i]);
    add_triple(-32768, -32768, -32768);
    for (int i = 0; i < 600; i++) begin
      // Some beats sit near the quadrant edges where entries reach one.
      if ($urandom_range(0, 4) == 0)
        add_triple(($urandom_range(0, 3) << 14) + $urandom_range(0, 6) - 3,
                   ($urandom_range(0, 3) << 14) + $urandom_range(0, 6) - 3,
                   $urandom_range(0, 65535));
      else
        add_triple($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: after a beat is taken, idles for its drawn gap, then presents
  // the next beat at a falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && !(start && busy)) begin
      if (wait_cnt != 0) begin
        start <= 1'b0;
        wait_cnt <= wait_cnt - 1;
      end else if (angle_q.size() > 0) begin
        in_i <= angle_q.pop_front();
        start <= 1'b1;
        wait_cnt <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: books accepted beats and checks each result strobe.
  always @(posedge clk_i) begin
    e2r_out_t want;
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        matrix_q.push_back(rotation_of(in_i));
        sent <= sent + 1;
      end
      if (valid_o) begin
        if (matrix_q.size() == 0) begin
          errors++;
          $display("result with no pending beat: %h", out_o);
        end else begin
          want = matrix_q.pop_front();
          if (out_o.r00 !== want.r00) report("r00", out_o.r00, want.r00);
          if (out_o.r01 !== want.r01) report("r01", out_o.r01, want.r01);
          if (out_o.r02 !== want.r02) report("r02", out_o.r02, want.r02);
          if (out_o.r10 !== want.r10) report("r10", out_o.r10, want.r10);
          if (out_o.r11 !== want.r11) report("r11", out_o.r11, want.r11);
          if (out_o.r12 !== want.r12) report("r12", out_o.r12, want.r12);
          if (out_o.r20 !== want.r20) report("r20", out_o.r20, want.r20);
          if (out_o.r21 !== want.r21) report("r21", out_o.r21, want.r21);
          if (out_o.r22 !== want.r22) report("r22", out_o.r22, want.r22);
        end
        received <= received + 1;
      end
      if (!stim_done && idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("euler_to_rotation_matrix regression: fail");
        $finish;
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (angle_q.size() == 0 && !start && matrix_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
    stim_done = 1'b1;
    $display("covered %0d angle triples, %0d matrices checked", sent, received);
    if (errors == 0 && matrix_q.size() == 0)
      $display("euler_to_rotation_matrix regression: pass");
    else
      $display("euler_to_rotation_matrix regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
design/e2r_pkg.sv
design/e2r_cell.sv
design/e2r_sincos.sv
design/euler_to_rotation_matrix.sv
design/e2r_checker.sv
tb/sv/euler_to_rotation_matrix_test.sv
